@@ rtl/max_subseq_sum_online_indices_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the maximum-subsequence-sum block
// Clocked on clk_i and held off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef MAX_SUBSEQ_SUM_ONLINE_INDICES_MACROS_SVH
`define MAX_SUBSEQ_SUM_ONLINE_INDICES_MACROS_SVH

// Property checked at every rising clock edge outside reset
`define MSSO_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same, with the antecedent and consequent given separately (next-cycle check)
`define MSSO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/msso_pkg.sv @@
// ----------------------------------------------------------------------------
// msso_pkg
// Shared widths, constants and the result type of the max-subsequence block.
// ----------------------------------------------------------------------------
package msso_pkg;

  localparam int OUT_SUM_W = 31;
  localparam int OUT_IDX_W = 10;
  localparam int SUM_W     = 32;

  // Saturation ceiling of the running sum
  localparam logic [OUT_SUM_W-1:0] SUM_CAP = {OUT_SUM_W{1'b1}};

  typedef struct packed {
    logic [OUT_SUM_W-1:0] max_sum;
    logic [OUT_IDX_W-1:0] left_index;
    logic [OUT_IDX_W-1:0] right_index;
    logic                 too_long;
  } result_t;

endpackage

@@ rtl/msso_kadane.sv @@
// ----------------------------------------------------------------------------
// msso_kadane
// Kadane recurrence: holds the per-sequence state and, for the item being
// stepped, forms the result that a last item reports. State clears on last.
// ----------------------------------------------------------------------------
module msso_kadane #(
  parameter int MAX_LEN      = 1024,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    step_i,
  input  logic [SAMPLE_WIDTH-1:0] sample_i,
  input  logic                    last_i,
  output msso_pkg::result_t       result_o
);
  import msso_pkg::*;

  localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CNT_W = $clog2(MAX_LEN + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_LEN);
  localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(MAX_LEN - 1);

  logic [SUM_W-1:0]     run_q, run_d;
  logic [OUT_SUM_W-1:0] best_q, best_d;
  logic [IDX_W-1:0]     start_q, start_d;
  logic [IDX_W-1:0]     left_q, left_d;
  logic [IDX_W-1:0]     right_q, right_d;
  logic                 allneg_q, allneg_d;
  logic [IDX_W-1:0]     zpos_q, zpos_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 over_q, over_d;

  logic                 sat;
  logic [IDX_W-1:0]     idx;
  logic [OUT_SUM_W-1:0] base;
  logic [SUM_W:0]       sum_ext;
  logic [SUM_W:0]       sample_ext;
  logic                 better;
  logic [IDX_W-1:0]     res_left, res_right;

  always_comb begin
    sat   = (cnt_q >= CNT_MAX);
    idx   = sat ? IDX_MAX : cnt_q[IDX_W-1:0];
    cnt_d = sat ? cnt_q : cnt_q + CNT_W'(1);
    over_d = over_q | sat;

    // a negative running sum restarts at this sample
    start_d = run_q[SUM_W-1] ? idx : start_q;
    base    = run_q[SUM_W-1] ? '0 : run_q[OUT_SUM_W-1:0];

    sample_ext = {{(SUM_W + 1 - SAMPLE_WIDTH){sample_i[SAMPLE_WIDTH-1]}}, sample_i};
    sum_ext    = {2'b00, base} + sample_ext;
    // positive result past 31 bits saturates
    if (!sum_ext[SUM_W] && sum_ext[SUM_W-1]) begin
      run_d = {1'b0, SUM_CAP};
    end else begin
      run_d = sum_ext[SUM_W-1:0];
    end

    allneg_d = allneg_q & sample_i[SAMPLE_WIDTH-1];
    zpos_d   = ((run_d == '0) && !allneg_d) ? idx : zpos_q;

    better  = !run_d[SUM_W-1] && (run_d[OUT_SUM_W-1:0] > best_q);
    best_d  = better ? run_d[OUT_SUM_W-1:0] : best_q;
    left_d  = better ? start_d : left_q;
    right_d = better ? idx : right_q;

    if (allneg_d) begin
      res_left  = '0;
      res_right = idx;
    end else if (best_d == '0) begin
      res_left  = zpos_d;
      res_right = zpos_d;
    end else begin
      res_left  = left_d;
      res_right = right_d;
    end

    result_o.max_sum     = best_d;
    result_o.left_index  = OUT_IDX_W'(res_left);
    result_o.right_index = OUT_IDX_W'(res_right);
    result_o.too_long    = over_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q    <= '0;
      best_q   <= '0;
      start_q  <= '0;
      left_q   <= '0;
      right_q  <= '0;
      allneg_q <= 1'b1;
      zpos_q   <= '0;
      cnt_q    <= '0;
      over_q   <= 1'b0;
    end else if (step_i) begin
      if (last_i) begin
        run_q    <= '0;
        best_q   <= '0;
        start_q  <= '0;
        left_q   <= '0;
        right_q  <= '0;
        allneg_q <= 1'b1;
        zpos_q   <= '0;
        cnt_q    <= '0;
        over_q   <= 1'b0;
      end else begin
        run_q    <= run_d;
        best_q   <= best_d;
        start_q  <= start_d;
        left_q   <= left_d;
        right_q  <= right_d;
        allneg_q <= allneg_d;
        zpos_q   <= zpos_d;
        cnt_q    <= cnt_d;
        over_q   <= over_d;
      end
    end
  end

endmodule

@@ rtl/max_subseq_sum_online_indices.sv @@
// ----------------------------------------------------------------------------
// max_subseq_sum_online_indices
// Online maximum contiguous subsequence sum with the indices of the best run.
// ----------------------------------------------------------------------------
// Takes one signed sample per transaction and returns one result on the
// transaction marked last: the best run sum (floor zero, saturated at 31 bits),
// the first and last index of that run and a flag for sequences longer than
// MAX_LEN (indices then stick at MAX_LEN-1). With only negative samples the
// indices are 0 and the last index; with a best sum of zero they both give the
// last position where the running sum came back to zero. A sample is taken
// every cycle unless the input stalls: it lands in an input register, the
// Kadane update then runs from that register in one add, saturate and
// compare path, and a last sample's result is loaded into the output
// register when that update steps, which raises valid_o. The input stalls
// only while a finished result is held by a stalled output.
module max_subseq_sum_online_indices #(
  parameter int MAX_LEN      = 1024,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  output logic                           stall_o,
  input  logic [SAMPLE_WIDTH-1:0]        sample_i,
  input  logic                           last_i,
  output logic                           valid_o,
  input  logic                           stall_i,
  output logic [msso_pkg::OUT_SUM_W-1:0] max_sum_o,
  output logic [msso_pkg::OUT_IDX_W-1:0] left_index_o,
  output logic [msso_pkg::OUT_IDX_W-1:0] right_index_o,
  output logic                           too_long_o
);
  import msso_pkg::*;

  logic                    in_valid_q;
  logic [SAMPLE_WIDTH-1:0] in_sample_q;
  logic                    in_last_q;
  logic                    out_valid_q;
  result_t                 out_q;
  result_t                 result;
  logic                    advance;
  logic                    accept;
  logic                    step;

  // the whole pipe moves unless a result is held by a stalled output
  assign advance = !out_valid_q || !stall_i;
  assign stall_o = in_valid_q && !advance;
  assign accept  = valid_i && !stall_o;
  assign step    = in_valid_q && advance;

  msso_kadane #(
    .MAX_LEN      (MAX_LEN),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_kadane (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .sample_i (in_sample_q),
    .last_i   (in_last_q),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= step && in_last_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_sample_q <= sample_i;
      in_last_q   <= last_i;
    end
    if (step && in_last_q) begin
      out_q <= result;
    end
  end

  assign valid_o       = out_valid_q;
  assign max_sum_o     = out_q.max_sum;
  assign left_index_o  = out_q.left_index;
  assign right_index_o = out_q.right_index;
  assign too_long_o    = out_q.too_long;

endmodule

@@ rtl/msso_checker.sv @@
// ----------------------------------------------------------------------------
// msso_checker
// Port-level checks on the max-subsequence block, bound to the top level.
// ----------------------------------------------------------------------------
`include "max_subseq_sum_online_indices_macros.svh"

module msso_checker #(
  parameter int MAX_LEN      = 1024,
  parameter int SAMPLE_WIDTH = 16
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           valid_i,
  input logic                           stall_o,
  input logic [SAMPLE_WIDTH-1:0]        sample_i,
  input logic                           last_i,
  input logic                           valid_o,
  input logic                           stall_i,
  input logic [msso_pkg::OUT_SUM_W-1:0] max_sum_o,
  input logic [msso_pkg::OUT_IDX_W-1:0] left_index_o,
  input logic [msso_pkg::OUT_IDX_W-1:0] right_index_o,
  input logic                           too_long_o
);

  // a stalled input transaction keeps its payload
  `MSSO_ASSERT_NEXT(a_in_hold, valid_i && stall_o, valid_i && $stable(sample_i) && $stable(last_i), "input changed while stalled")

  // a held result transaction keeps its payload
  `MSSO_ASSERT_NEXT(a_out_hold, valid_o && stall_i, valid_o && $stable(max_sum_o) && $stable(left_index_o) && $stable(right_index_o) && $stable(too_long_o), "result changed while stalled")

  // input back-pressure only comes from a stalled, full output
  `MSSO_ASSERT(a_stall_cause, !stall_o || (valid_o && stall_i), "input stalled without output stall")

  // the best run never ends before it starts (not checked for MAX_LEN above 1024)
  `MSSO_ASSERT(a_run_order, !valid_o || (MAX_LEN > 1024) || (left_index_o <= right_index_o), "left index past right index")

endmodule

bind max_subseq_sum_online_indices msso_checker #(
  .MAX_LEN      (MAX_LEN),
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_msso_checker (.*);

@@ verif/max_subseq_sum_online_indices_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_subseq_sum_online_indices_test
// Drives signed sample sequences into the max-subsequence block and checks
// every best-run result (sum, left/right index, too-long flag) against a
// Kadane predictor kept in the bench, or against the want field of a typed
// directed row. A directed table covers the extremes and the all-negative
// and zero-sum cases. Random sequences follow under three sender/receiver idling mixes.
// ----------------------------------------------------------------------------
module max_subseq_sum_online_indices_test;
  import msso_pkg::*;

  localparam int MAX_LEN  = 1024;
  localparam int SAMPLE_W = 16;
  localparam logic signed [32:0] RUN_CEIL = {2'b00, SUM_CAP};

  typedef enum int {WIDE, NEAR_ZERO, SINKING, EXTREMES} seq_flavor_e;

  // reps copies of sample; last applies to the final copy only
  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                last;
    int                  reps;
    logic                typed;
    result_t             want;
  } stim_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  valid_i;
  logic                  stall_o;
  logic [SAMPLE_W-1:0]   sample_i;
  logic                  last_i;
  logic                  valid_o;
  logic                  stall_i = 1'b0;
  logic [OUT_SUM_W-1:0]  max_sum_o;
  logic [OUT_IDX_W-1:0]  left_index_o;
  logic [OUT_IDX_W-1:0]  right_index_o;
  logic                  too_long_o;

  int send_idle_pct;
  int recv_idle_pct;
  int mismatch_count = 0;

  result_t pending_runs [$];
  result_t head_run;

  // Kadane predictor state
  logic signed [31:0] run_sum;
  logic [30:0]        best_sum;
  logic [9:0]         start_idx;
  logic [9:0]         best_lo;
  logic [9:0]         best_hi;
  logic [9:0]         zero_pos;
  logic [10:0]        n_seen;
  logic               all_neg;
  logic               over_len;

  stim_row_t directed_rows [18] = '{
    '{16'h7FFF, 1'b1, 1,     1'b1, '{31'd32767, 10'd0, 10'd0, 1'b0}},
    '{16'h8000, 1'b1, 1,     1'b1, '{31'd0, 10'd0, 10'd0, 1'b0}},
    '{16'hFFFF, 1'b0, 1,     1'b0, '0},
    '{16'hFFFB, 1'b0, 1,     1'b0, '0},
    '{16'h8000, 1'b1, 1,     1'b1, '{31'd0, 10'd0, 10'd2, 1'b0}},
    // best sum zero: both indices at the zero position
    '{16'hFFFD, 1'b0, 1,     1'b0, '0},
    '{16'h0000, 1'b0, 1,     1'b0, '0},
    '{16'hFFFE, 1'b1, 1,     1'b1, '{31'd0, 10'd1, 10'd1, 1'b0}},
    '{16'h0002, 1'b0, 1,     1'b0, '0},
    '{16'hFFFF, 1'b0, 1,     1'b0, '0},
    '{16'h0003, 1'b1, 1,     1'b0, '0},
    '{16'h0005, 1'b0, 1,     1'b0, '0},
    '{16'hFFFB, 1'b0, 1,     1'b0, '0},
    '{16'h0004, 1'b1, 1,     1'b0, '0},
    '{16'h0000, 1'b1, 1,     1'b1, '{31'd0, 10'd0, 10'd0, 1'b0}},
    '{16'h7FFF, 1'b0, 1,     1'b0, '0},
    '{16'h8000, 1'b0, 1,     1'b0, '0},
    '{16'h7FFF, 1'b1, 1,     1'b0, '0}
  };

  max_subseq_sum_online_indices #(
    .MAX_LEN     (MAX_LEN),
    .SAMPLE_WIDTH(SAMPLE_W)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (valid_i),
    .stall_o      (stall_o),
    .sample_i     (sample_i),
    .last_i       (last_i),
    .valid_o      (valid_o),
    .stall_i      (stall_i),
    .max_sum_o    (max_sum_o),
    .left_index_o (left_index_o),
    .right_index_o(right_index_o),
    .too_long_o   (too_long_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic void clear_kadane();
    run_sum   = '0;
    best_sum  = '0;
    start_idx = '0;
    best_lo   = '0;
    best_hi   = '0;
    zero_pos  = '0;
    n_seen    = '0;
    all_neg   = 1'b1;
    over_len  = 1'b0;
  endfunction

  // Advances the predictor by one sample; returns 1 when a result is due
  function automatic bit kadane_step(input logic signed [SAMPLE_W-1:0] s, input logic l,
                                     output result_t r);
    logic [9:0]         idx;
    logic signed [32:0] acc;
    r = '0;
    if (n_seen >= MAX_LEN) begin
      idx      = 10'(MAX_LEN - 1);
      over_len = 1'b1;
    end else begin
      idx    = n_seen[9:0];
      n_seen = n_seen + 11'd1;
    end
    if (run_sum < 0) begin
      run_sum   = '0;
      start_idx = idx;
    end
    if (s >= 0) all_neg = 1'b0;
    acc = 33'(run_sum) + 33'(s);
    if (acc > RUN_CEIL) acc = RUN_CEIL;
    run_sum = acc[31:0];
    if (run_sum == 0 && !all_neg) zero_pos = idx;
    if (run_sum > $signed({1'b0, best_sum})) begin
      best_sum = run_sum[30:0];
      best_lo  = start_idx;
      best_hi  = idx;
    end
    if (!l) return 1'b0;
    r.max_sum     = best_sum;
    r.left_index  = best_lo;
    r.right_index = best_hi;
    r.too_long    = over_len;
    if (all_neg) begin
      r.left_index  = '0;
      r.right_index = idx;
    end else if (best_sum == 0) begin
      r.left_index  = zero_pos;
      r.right_index = zero_pos;
    end
    clear_kadane();
    return 1'b1;
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample(input seq_flavor_e flavor);
    logic [31:0] r32;
    case (flavor)
      WIDE: r32 = $urandom;
      NEAR_ZERO: r32 = $urandom_range(0, 16) - 8;
      SINKING: begin
        if ($urandom_range(0, 3) == 0) r32 = $urandom_range(0, 200);
        else r32 = 0 - $urandom_range(1, 4000);
      end
      default: begin
        case ($urandom_range(0, 4))
          0: r32 = 32'h7FFF;
          1: r32 = 32'h8000;
          2: r32 = 32'h0000;
          3: r32 = 32'hFFFF;
          default: r32 = 32'h0001;
        endcase
      end
    endcase
    return r32[SAMPLE_W-1:0];
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance
  task automatic send_sample(input logic [SAMPLE_W-1:0] s, input logic l,
                             input logic typed, input result_t want);
    result_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      valid_i <= 1'b0;
      @(negedge clk_i);
    end
    valid_i  <= 1'b1;
    sample_i <= s;
    last_i   <= l;
    @(posedge clk_i);
    while (stall_o) @(posedge clk_i);
    if (kadane_step(s, l, predicted)) pending_runs.push_back(typed ? want : predicted);
    @(negedge clk_i);
  endtask

  task automatic send_random_runs(input int n_items);
    int          sent;
    int          len;
    seq_flavor_e flavor;
    sent = 0;
    while (sent < n_items) begin
      len    = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 12) : $urandom_range(13, 40);
      flavor = seq_flavor_e'($urandom_range(0, 3));
      for (int k = 0; k < len; k++) send_sample(pick_sample(flavor), k == len - 1, 1'b0, '0);
      sent += len;
    end
  endtask

  function automatic void check_field(input string what, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
      mismatch_count++;
    end
  endfunction

  always @(negedge clk_i) begin
    stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && valid_o && !stall_i) begin
      if (pending_runs.size() == 0) begin
        $display("%0t: result with none pending: expected nothing, got sum %0d left %0d right %0d too_long %0b",
                 $time, max_sum_o, left_index_o, right_index_o, too_long_o);
        mismatch_count++;
      end else begin
        head_run = pending_runs.pop_front();
        check_field("max_sum", 32'(head_run.max_sum), 32'(max_sum_o));
        check_field("left_index", 32'(head_run.left_index), 32'(left_index_o));
        check_field("right_index", 32'(head_run.right_index), 32'(right_index_o));
        check_field("too_long", 32'(head_run.too_long), 32'(too_long_o));
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    valid_i       = 1'b0;
    sample_i      = '0;
    last_i        = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    clear_kadane();
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 12;
          recv_idle_pct = 56;
        end
        1: begin
          send_idle_pct = 56;
          recv_idle_pct = 12;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      if (phase == 0) begin
        foreach (directed_rows[i]) begin
          for (int k = 0; k < directed_rows[i].reps; k++) begin
            send_sample(directed_rows[i].sample,
                        directed_rows[i].last && (k == directed_rows[i].reps - 1),
                        directed_rows[i].typed, directed_rows[i].want);
          end
        end
      end
      send_random_runs(183);
    end
    valid_i <= 1'b0;

    while (pending_runs.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #300_000;
    $display("timeout with %0d results outstanding", pending_runs.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
